// ----- sv/exact_size_class_block_pool_macros.svh -----
// Assertion helpers used by the pool datapath (escbp_dp).
`ifndef EXACT_SIZE_CLASS_BLOCK_POOL_MACROS_SVH
`define EXACT_SIZE_CLASS_BLOCK_POOL_MACROS_SVH

// same-cycle implication
`define ESCBP_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("exact_size_class_block_pool: assertion failed");

// next-cycle implication
`define ESCBP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("exact_size_class_block_pool: assertion failed");

`endif

// ----- sv/escbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package escbp_pkg;

  localparam int MAX_ENTRIES = 2048;
  // must be a power of two
  localparam int ALIGN_BYTES = 64;
  localparam int ALIGN_LOG2  = $clog2(ALIGN_BYTES);

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W  = 32;
  localparam int RSIZE_W = ADDR_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_RETURN = 2'd1,
    OP_ISSUE  = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALLOC_FAIL = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_IDLE       = 3'd3,
    ST_NOT_IDLE   = 3'd4
  } status_t;

  typedef struct packed {
    logic [RSIZE_W-1:0] rsize;
    logic [ADDR_W-1:0]  offset;
    logic               idle;
    logic               live;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;
    logic scan;
    logic capture;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/escbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module escbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/escbp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module escbp_ctrl
  import escbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } fsm_t;

  fsm_t fsm;

  assign s_tready = (fsm == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = (fsm == S_IDLE) && s_tvalid;
    cmd.scan    = (fsm == S_SCAN);
    cmd.capture = (fsm == S_SCAN) && stat.hit;
    cmd.commit  = (fsm == S_DECIDE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      unique case (fsm)
        S_IDLE: begin
          if (s_tvalid) begin
            fsm <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat.hit || stat.scan_end) begin
            fsm <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stat.out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/escbp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "exact_size_class_block_pool_macros.svh"
module escbp_dp
  import escbp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic [63:0]          s_tdata,
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,
  output logic [2:0]                m_tuser,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  output logic                      ram_we,
  output logic [IDX_W-1:0]          ram_waddr,
  output logic [ENTRY_W-1:0]        ram_wdata,
  output logic                      ram_re,
  output logic [IDX_W-1:0]          ram_raddr,
  input  wire logic [ENTRY_W-1:0]   ram_rdata
);

  logic [ADDR_W-1:0]  base_q, cap_q;
  logic [CNT_W-1:0]   used_q, used_next;
  logic [ADDR_W-1:0]  carved_q, carved_next;

  op_t                op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [RSIZE_W-1:0] rounded_q;
  logic               skip_q;

  logic [CNT_W-1:0]   rd_idx;
  logic               cmp_vld;
  logic [IDX_W-1:0]   cmp_idx;
  logic               found_q;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_ent;

  logic [ADDR_W-1:0]  out_address;
  status_t            out_status;
  logic [ADDR_W-1:0]  out_bytes;

  op_t                in_op;
  logic [ADDR_W-1:0]  in_size, in_addr;
  logic [RSIZE_W-1:0] in_rounded;
  logic               in_skip;

  entry_t             rd_ent, wr_ent;
  logic               match;
  logic [ADDR_W-1:0]  room;
  logic               new_carve;
  logic [ADDR_W-1:0]  res_address;
  status_t            res_status;

  assign in_op   = op_t'(s_tuser);
  assign in_size = s_tdata[31:0];
  assign in_addr = s_tdata[63:32];
  // round up to the alignment
  assign in_rounded = ({1'b0, in_size} + RSIZE_W'(ALIGN_BYTES - 1))
                      & ~RSIZE_W'(ALIGN_BYTES - 1);
  assign in_skip = (in_op == OP_ALLOC) ? ((in_size == '0) || (in_size > cap_q))
                                        : ((in_op == OP_FREE) && (in_addr == '0));

  assign rd_ent = entry_t'(ram_rdata);
  always_comb begin
    if (op_q == OP_ALLOC) begin
      match = !rd_ent.live && (rd_ent.rsize == rounded_q);
    end else begin
      match = rd_ent.live && ((base_q + rd_ent.offset) == addr_q);
    end
  end

  assign ram_re    = cmd.scan && !skip_q && (rd_idx < used_q);
  assign ram_raddr = rd_idx[IDX_W-1:0];

  assign stat.hit      = cmp_vld && match;
  assign stat.scan_end = skip_q || (!cmp_vld && (rd_idx >= used_q));
  assign stat.out_free = !m_tvalid || m_tready;

  assign room = (cap_q >= carved_q) ? (cap_q - carved_q) : '0;

  always_comb begin
    res_address = '0;
    res_status  = ST_OK;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx;
    wr_ent      = hit_ent;
    new_carve   = 1'b0;
    used_next   = used_q;
    carved_next = carved_q;
    priority if (op_q == OP_ALLOC) begin
      priority if (skip_q) begin
        res_status = ST_ALLOC_FAIL;
      end else if (found_q) begin
        ram_we      = cmd.commit;
        wr_ent.live = 1'b1;
        wr_ent.idle = 1'b0;
        res_address = base_q + hit_ent.offset;
      end else if ((used_q >= CNT_W'(MAX_ENTRIES)) || (rounded_q > {1'b0, room})) begin
        res_status = ST_ALLOC_FAIL;
      end else begin
        new_carve     = cmd.commit;
        ram_we        = cmd.commit;
        ram_waddr     = used_q[IDX_W-1:0];
        wr_ent.rsize  = rounded_q;
        wr_ent.offset = carved_q;
        wr_ent.live   = 1'b1;
        wr_ent.idle   = 1'b0;
        used_next     = used_q + 1'b1;
        carved_next   = carved_q + rounded_q[ADDR_W-1:0];
        res_address   = base_q + carved_q;
      end
    end else if (skip_q) begin
      res_status = ST_OK;
    end else if (!found_q) begin
      res_status = ST_UNKNOWN;
    end else if (op_q == OP_ISSUE) begin
      if (!hit_ent.idle) begin
        res_status = ST_NOT_IDLE;
      end else begin
        ram_we      = cmd.commit;
        wr_ent.idle = 1'b0;
        res_address = base_q + hit_ent.offset;
      end
    end else if (hit_ent.idle) begin
      res_status = ST_IDLE;
    end else if (op_q == OP_RETURN) begin
      ram_we      = cmd.commit;
      wr_ent.idle = 1'b1;
    end else begin
      ram_we      = cmd.commit;
      wr_ent.live = 1'b0;
      wr_ent.idle = 1'b1;
    end
  end

  assign ram_wdata = wr_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_q   <= '0;
      cap_q    <= '0;
      used_q   <= '0;
      carved_q <= '0;
      cmp_vld  <= 1'b0;
      found_q  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REGION_BASE:     base_q <= cfg_data;
          REG_REGION_CAPACITY: cap_q  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        cmp_vld <= 1'b0;
        found_q <= 1'b0;
      end else begin
        cmp_vld <= ram_re;
        if (cmd.capture) begin
          found_q <= 1'b1;
        end
      end
      if (cmd.commit) begin
        used_q   <= used_next;
        carved_q <= carved_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= in_op;
      addr_q    <= in_addr;
      rounded_q <= in_rounded;
      skip_q    <= in_skip;
      rd_idx    <= '0;
    end else if (ram_re) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (ram_re) begin
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
    if (cmd.capture) begin
      hit_idx <= cmp_idx;
      hit_ent <= rd_ent;
    end
    if (cmd.commit) begin
      out_address <= res_address;
      out_status  <= res_status;
      out_bytes   <= carved_next;
    end
  end

  assign m_tdata = {out_bytes, out_address};
  assign m_tuser = out_status;

  `ESCBP_ASSERT_IMPL(a_read_below_used, clk, rst, ram_re, rd_idx < used_q)
  `ESCBP_ASSERT_IMPL(a_used_bounded, clk, rst, 1'b1, used_q <= CNT_W'(MAX_ENTRIES))
  `ESCBP_ASSERT_IMPL(a_commit_slot_free, clk, rst, cmd.commit, !m_tvalid || m_tready)
  `ESCBP_ASSERT_NEXT(a_carve_grows_table, clk, rst, new_carve, used_q == $past(used_q) + 1'b1)

endmodule
`default_nettype wire

// ----- sv/exact_size_class_block_pool.sv -----
// Flow: an accepted request scans the used entries of the table in order and stops at
//   the first match; nothing is scanned for early alloc fails, free of address 0 or an
//   empty table. At most 2048 entries are scanned.
// Throughput: one item at a time, set by the linear scan over the single read port
//   of the entry table; a full table of 2048 entries gives the longest items.
// Reset (synchronous): config, entry count and bump offset clear; the table does not.
`timescale 1ns / 1ps
`default_nettype none
module exact_size_class_block_pool
  import escbp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [63:0]          s_tdata,   // req_size[31:0], block_address[63:32]
  input  wire logic [1:0]           s_tuser,   // operation[1:0]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [63:0]               m_tdata,   // out_address[31:0], bytes_in_use[63:32]
  output logic [2:0]                m_tuser,   // status[2:0]
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  escbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  escbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  escbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
